/* hw/rtl/eocbr_pkg.sv */
// Shared widths, reset values and codes for the EMG offset-calibrated block RMS unit.
package eocbr_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int GAIN_BITS     = 12;
    localparam int CLEN_BITS     = 13;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CENT_BITS     = 13;
    localparam int NORM_BITS     = 16;
    localparam int MAG_BITS      = 15;
    localparam int SQ_BITS       = 2 * MAG_BITS;
    localparam int CSUM_BITS     = SAMPLE_BITS + 12;

    localparam int MAX_BLOCK_DEF = 4096;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(2048);
    localparam logic [CLEN_BITS-1:0] CLEN_RESET = CLEN_BITS'(1024);
    localparam logic [CLEN_BITS-1:0] CALIB_MAX  = CLEN_BITS'(4096);
    localparam logic [MAG_BITS-1:0]  NORM_MAX   = MAG_BITS'(32767);
    localparam logic [MAG_BITS-1:0]  SAT_LEVEL  = MAG_BITS'(32112);

    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN      = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CALIB_LEN = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CALIB  = 1'b1;

endpackage

/* hw/rtl/eocbr_if.sv */
// Sample, result and configuration channel interfaces.
interface eocbr_in_if import eocbr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_in_block;

    modport source (output valid, output opcode, output sample, output last_in_block,
                    input ready);
    modport sink   (input valid, input opcode, input sample, input last_in_block,
                    output ready);
endinterface

interface eocbr_out_if import eocbr_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [CENT_BITS-1:0] centered;
    logic signed [NORM_BITS-1:0] norm;
    logic                        saturated;
    logic                        calibrating;
    logic                        baseline_ready;
    logic                        block_done;
    logic [MAG_BITS-1:0]         block_peak;
    logic [MAG_BITS-1:0]         block_rms;

    modport source (output valid, output centered, output norm, output saturated,
                    output calibrating, output baseline_ready, output block_done,
                    output block_peak, output block_rms, input ready);
    modport sink   (input valid, input centered, input norm, input saturated,
                    input calibrating, input baseline_ready, input block_done,
                    input block_peak, input block_rms, output ready);
endinterface

interface eocbr_cfg_if import eocbr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/eocbr_csu.sv */
// Shared compare-subtract unit used for every divide and square-root step.
module eocbr_csu #(
    parameter int W = 18
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_diff,
    output logic         o_ge
);
    logic [W:0] w_sub;

    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[W];
    assign o_diff = w_sub[W-1:0];
endmodule

/* hw/rtl/emg_offset_calibrated_block_rms_unit.sv */
// Top level of the EMG offset-calibrated block RMS unit: sequencer and state.
// One item is in flight at a time and the sample channel is ready only while the
// sequencer is idle; a finished result waits in the output register, so the next
// item can be taken before it is collected. All division and square-root work runs
// through one compare-subtract unit, one quotient bit or root digit per cycle.
// A start command goes straight to output; a sample during calibration or without
// a baseline passes only the block check. The sample ending calibration divides
// for a 12-bit quotient; a run sample divides for a 15-bit quotient unless at full
// scale, then is squared and accumulated. A sample that closes a block in run mode
// adds a 30-bit mean-square quotient, then 15 root digits. Configuration transfers
// are taken in any cycle and must only be issued while the unit is idle.
module emg_offset_calibrated_block_rms_unit import eocbr_pkg::*; #(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eocbr_in_if.sink    i_in,
    eocbr_cfg_if.sink   i_cfg,
    eocbr_out_if.source o_out
);
    localparam int BLW   = $clog2(MAX_BLOCK + 1);
    localparam int SSW   = BLW + SQ_BITS;
    localparam int DVW   = (BLW > CLEN_BITS) ? BLW : CLEN_BITS;
    localparam int UW    = ((DVW + 1) > (MAG_BITS + 3)) ? (DVW + 1) : (MAG_BITS + 3);
    localparam int CNT_W = $clog2(SQ_BITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_CHK  = 3'd5;
    localparam logic [2:0] ST_SQRT = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    localparam logic [1:0] K_CAL  = 2'd0;
    localparam logic [1:0] K_NORM = 2'd1;
    localparam logic [1:0] K_BLK  = 2'd2;

    logic [GAIN_BITS-1:0]        r_gain;
    logic [CLEN_BITS-1:0]        r_clen;
    logic                        r_calib;
    logic                        r_bvalid;
    logic [SAMPLE_BITS-1:0]      r_base;
    logic [CSUM_BITS-1:0]        r_csum;
    logic [CLEN_BITS-1:0]        r_cseen;
    logic [BLW-1:0]              r_blen;
    logic [MAG_BITS-1:0]         r_peak;
    logic [SSW-1:0]              r_sqsum;

    logic [2:0]                  r_state;
    logic [1:0]                  r_kind;
    logic [CNT_W-1:0]            r_cnt;
    logic [UW-1:0]               r_rem;
    logic [SQ_BITS-1:0]          r_quo;
    logic [DVW-1:0]              r_dvs;
    logic [MAG_BITS-1:0]         r_root;
    logic [SQ_BITS-1:0]          r_prod;

    logic signed [CENT_BITS-1:0] r_cent;
    logic                        r_neg;
    logic [MAG_BITS-1:0]         r_nmag;
    logic                        r_sat;
    logic                        r_close;
    logic                        r_bstat;
    logic [MAG_BITS-1:0]         r_bpeak;

    logic                        r_ovalid;
    logic signed [CENT_BITS-1:0] r_o_cent;
    logic signed [NORM_BITS-1:0] r_o_norm;
    logic                        r_o_sat;
    logic                        r_o_cal;
    logic                        r_o_bready;
    logic                        r_o_done;
    logic [MAG_BITS-1:0]         r_o_peak;
    logic [MAG_BITS-1:0]         r_o_rms;

    logic                        in_fire;
    logic [CSUM_BITS-1:0]        n_csum;
    logic [CLEN_BITS-1:0]        n_cseen;
    logic [CLEN_BITS-1:0]        calib_tgt;
    logic signed [CENT_BITS-1:0] n_cent;
    logic signed [CENT_BITS-1:0] cent_neg;
    logic [SAMPLE_BITS-1:0]      cent_mag;
    logic [GAIN_BITS-1:0]        gain_eff;
    logic [BLW-1:0]              n_blen;
    logic                        n_close;
    logic                        n_bstat;
    logic [NORM_BITS-1:0]        norm_pos;
    logic                        out_load;

    logic [UW-1:0]               csu_a;
    logic [UW-1:0]               csu_b;
    logic [UW-1:0]               csu_diff;
    logic                        csu_ge;

    eocbr_csu #(.W(UW)) u_csu (
        .i_a   (csu_a),
        .i_b   (csu_b),
        .o_diff(csu_diff),
        .o_ge  (csu_ge)
    );

    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_csum   = r_csum + CSUM_BITS'(i_in.sample);
        n_cseen  = r_cseen + 1'b1;
        if (r_clen == '0) begin
            calib_tgt = CLEN_BITS'(1);
        end else if (r_clen > CALIB_MAX) begin
            calib_tgt = CALIB_MAX;
        end else begin
            calib_tgt = r_clen;
        end
        n_cent   = $signed({1'b0, i_in.sample}) - $signed({1'b0, r_base});
        cent_neg = -n_cent;
        cent_mag = n_cent[CENT_BITS-1] ? cent_neg[SAMPLE_BITS-1:0]
                                       : n_cent[SAMPLE_BITS-1:0];
        gain_eff = (r_gain == '0) ? GAIN_BITS'(1) : r_gain;
        n_blen   = r_blen + 1'b1;
        n_close  = i_in.last_in_block || (n_blen >= BLW'(MAX_BLOCK));
        n_bstat  = r_close && !r_calib && r_bvalid;
        norm_pos = {1'b0, r_nmag};
        out_load = (r_state == ST_OUT) && (!r_ovalid || o_out.ready);
    end

    always_comb begin
        if (r_state == ST_SQRT) begin
            csu_a = {r_rem[UW-3:0], r_quo[SQ_BITS-1:SQ_BITS-2]};
            csu_b = UW'({r_root, 2'b01});
        end else begin
            csu_a = {r_rem[UW-2:0], r_quo[SQ_BITS-1]};
            csu_b = UW'(r_dvs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_clen   <= CLEN_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_GAIN:      r_gain <= i_cfg.data[GAIN_BITS-1:0];
                CFG_CALIB_LEN: r_clen <= i_cfg.data[CLEN_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_calib  <= 1'b0;
            r_bvalid <= 1'b0;
            r_base   <= '0;
            r_csum   <= '0;
            r_cseen  <= '0;
            r_blen   <= '0;
            r_peak   <= '0;
            r_sqsum  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_cent  <= '0;
                        r_neg   <= 1'b0;
                        r_nmag  <= '0;
                        r_sat   <= 1'b0;
                        r_close <= 1'b0;
                        r_bstat <= 1'b0;
                        if (i_in.opcode == OP_CALIB) begin
                            r_calib  <= 1'b1;
                            r_bvalid <= 1'b0;
                            r_csum   <= '0;
                            r_cseen  <= '0;
                            r_blen   <= '0;
                            r_peak   <= '0;
                            r_sqsum  <= '0;
                            r_state  <= ST_OUT;
                        end else begin
                            r_blen  <= n_blen;
                            r_close <= n_close;
                            if (r_calib) begin
                                r_csum  <= n_csum;
                                r_cseen <= n_cseen;
                                if (n_cseen >= calib_tgt) begin
                                    r_rem   <= UW'(n_csum[CSUM_BITS-1:SAMPLE_BITS]);
                                    r_quo   <= {n_csum[SAMPLE_BITS-1:0],
                                                {(SQ_BITS-SAMPLE_BITS){1'b0}}};
                                    r_dvs   <= DVW'(n_cseen);
                                    r_cnt   <= CNT_W'(SAMPLE_BITS);
                                    r_kind  <= K_CAL;
                                    r_state <= ST_DIV;
                                end else begin
                                    r_state <= ST_CHK;
                                end
                            end else if (r_bvalid) begin
                                r_cent <= n_cent;
                                r_neg  <= n_cent[CENT_BITS-1];
                                if (cent_mag >= gain_eff) begin
                                    r_nmag  <= NORM_MAX;
                                    r_state <= ST_MUL;
                                end else begin
                                    r_rem   <= UW'(cent_mag);
                                    r_quo   <= '0;
                                    r_dvs   <= DVW'(gain_eff);
                                    r_cnt   <= CNT_W'(MAG_BITS);
                                    r_kind  <= K_NORM;
                                    r_state <= ST_DIV;
                                end
                            end else begin
                                r_state <= ST_CHK;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    r_rem <= csu_ge ? csu_diff : csu_a;
                    r_quo <= {r_quo[SQ_BITS-2:0], csu_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    unique case (r_kind)
                        K_CAL: begin
                            r_base   <= r_quo[SAMPLE_BITS-1:0];
                            r_calib  <= 1'b0;
                            r_bvalid <= 1'b1;
                            r_state  <= ST_CHK;
                        end
                        K_NORM: begin
                            r_nmag  <= r_quo[MAG_BITS-1:0];
                            r_state <= ST_MUL;
                        end
                        K_BLK: begin
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_cnt   <= CNT_W'(MAG_BITS);
                            r_state <= ST_SQRT;
                        end
                        default: r_state <= ST_CHK;
                    endcase
                end
                ST_MUL: begin
                    r_prod  <= SQ_BITS'(r_nmag) * SQ_BITS'(r_nmag);
                    r_sat   <= (r_nmag > SAT_LEVEL);
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_nmag > r_peak) begin
                        r_peak <= r_nmag;
                    end
                    r_sqsum <= r_sqsum + SSW'(r_prod);
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    r_bstat <= n_bstat;
                    if (r_close) begin
                        r_blen  <= '0;
                        r_peak  <= '0;
                        r_sqsum <= '0;
                        r_bpeak <= r_peak;
                    end
                    if (n_bstat) begin
                        r_rem   <= UW'(r_sqsum[SSW-1:SQ_BITS]);
                        r_quo   <= r_sqsum[SQ_BITS-1:0];
                        r_dvs   <= DVW'(r_blen);
                        r_cnt   <= CNT_W'(SQ_BITS);
                        r_kind  <= K_BLK;
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_SQRT: begin
                    r_rem  <= csu_ge ? csu_diff : csu_a;
                    r_quo  <= {r_quo[SQ_BITS-3:0], 2'b00};
                    r_root <= {r_root[MAG_BITS-2:0], csu_ge};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_cent   <= r_cent;
            r_o_norm   <= r_neg ? -$signed(norm_pos) : $signed(norm_pos);
            r_o_sat    <= r_sat;
            r_o_cal    <= r_calib;
            r_o_bready <= r_bvalid;
            r_o_done   <= r_close;
            r_o_peak   <= r_bstat ? r_bpeak : '0;
            r_o_rms    <= r_bstat ? r_root : '0;
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.centered       = r_o_cent;
    assign o_out.norm           = r_o_norm;
    assign o_out.saturated      = r_o_sat;
    assign o_out.calibrating    = r_o_cal;
    assign o_out.baseline_ready = r_o_bready;
    assign o_out.block_done     = r_o_done;
    assign o_out.block_peak     = r_o_peak;
    assign o_out.block_rms      = r_o_rms;

endmodule

/* hw/rtl/eocbr_chk.sv */
// Port-level assertion checker for the EMG offset-calibrated block RMS unit, with bind.
module eocbr_chk import eocbr_pkg::*; (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic signed [CENT_BITS-1:0] i_centered,
    input logic signed [NORM_BITS-1:0] i_norm,
    input logic                        i_saturated,
    input logic                        i_calibrating,
    input logic                        i_baseline_ready,
    input logic                        i_block_done,
    input logic [MAG_BITS-1:0]         i_block_peak,
    input logic [MAG_BITS-1:0]         i_block_rms
);
    localparam logic signed [NORM_BITS-1:0] SAT_POS = NORM_BITS'(32112);
    localparam logic signed [NORM_BITS-1:0] SAT_NEG = -NORM_BITS'(32112);

    // one item in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample channel ready right after a transfer");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |-> (i_norm > SAT_POS) || (i_norm < SAT_NEG))
        else $error("saturation flag without large norm");

    a_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_block_done |-> (i_block_peak == '0) && (i_block_rms == '0))
        else $error("block stats on a non-closing result");

    a_rms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_block_rms <= i_block_peak)
        else $error("block rms above block peak");

    a_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_calibrating |->
            !i_baseline_ready && (i_centered == '0) && (i_norm == '0))
        else $error("output active while calibrating");
endmodule

bind emg_offset_calibrated_block_rms_unit eocbr_chk u_eocbr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_centered      (o_out.centered),
    .i_norm          (o_out.norm),
    .i_saturated     (o_out.saturated),
    .i_calibrating   (o_out.calibrating),
    .i_baseline_ready(o_out.baseline_ready),
    .i_block_done    (o_out.block_done),
    .i_block_peak    (o_out.block_peak),
    .i_block_rms     (o_out.block_rms)
);
